### design/pgo_pkg.sv
// Package: shared types and constants of the perpendicular greedy order unit.
package pgo_pkg;

  localparam int MAX_IMAGES = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int SCORE_W    = 42;
  localparam int TERM_W     = 32;
  localparam int COMP_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } dir_t;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [COMP_W-1:0] dir_x;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_z;
    logic [IDX_W-1:0]         start_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] order_position;
    logic [IDX_W-1:0] image_index;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic             chosen;
    logic [SCORE_W-1:0] score;
  } score_ent_t;

  typedef struct packed {
    logic             clr;
    logic             first;
    logic             sub;
    logic [IDX_W-1:0] prev_idx;
    dir_t             prev_vec;
    dir_t             old_vec;
  } walk_ctl_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    score_ent_t       data;
  } score_wr_t;

endpackage

### design/pgo_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pgo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pgo_walk.sv
// Score update pipeline: dot terms, accumulate, window subtract, write back, argmin.
module pgo_walk (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pgo_pkg::walk_ctl_t      ctl,
  input  logic                    issue_valid,
  input  logic [pgo_pkg::IDX_W-1:0] issue_idx,
  input  pgo_pkg::dir_t           dir_q,
  input  pgo_pkg::score_ent_t     score_q,
  output pgo_pkg::score_wr_t      score_wr,
  output logic                    busy,
  output logic                    found,
  output logic [pgo_pkg::IDX_W-1:0] best_idx
);
  import pgo_pkg::*;

  logic                v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]    j0_r, j1_r, j2_r, j3_r, j4_r;
  logic                ch1_r, ch2_r, ch3_r, ch4_r;
  logic [SCORE_W-1:0]  sc1_r, sc2_r, sc3_r, sc4_r;
  logic signed [2*COMP_W-1:0] pp_r [6];
  logic [TERM_W-1:0]   a2_r, d2_r, d3_r;
  logic                found_r;
  logic [SCORE_W-1:0]  best_sc_r;
  logic [IDX_W-1:0]    best_r;

  logic signed [2*COMP_W+1:0] dot_a, dot_d, abs_a, abs_d;
  logic [SCORE_W:0]    sum3;
  logic [SCORE_W-1:0]  sc4_nxt;

  always_comb begin
    dot_a = 34'(pp_r[0]) + 34'(pp_r[1]) + 34'(pp_r[2]);
    dot_d = 34'(pp_r[3]) + 34'(pp_r[4]) + 34'(pp_r[5]);
    abs_a = dot_a[2*COMP_W+1] ? -dot_a : dot_a;
    abs_d = dot_d[2*COMP_W+1] ? -dot_d : dot_d;
    sum3  = {1'b0, sc2_r} + {11'd0, a2_r};
    if (ctl.sub) begin
      sc4_nxt = (sc3_r > {10'd0, d3_r}) ? sc3_r - {10'd0, d3_r} : '0;
    end else begin
      sc4_nxt = sc3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v0_r <= issue_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (ctl.clr) begin
        found_r <= 1'b0;
      end else if (v4_r && !ch4_r && (!found_r || sc4_r < best_sc_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    j0_r <= issue_idx;
    j1_r <= j0_r;
    ch1_r <= (j0_r == ctl.prev_idx) || (!ctl.first && score_q.chosen);
    sc1_r <= ctl.first ? '0 : score_q.score;
    pp_r[0] <= ctl.prev_vec.x * dir_q.x;
    pp_r[1] <= ctl.prev_vec.y * dir_q.y;
    pp_r[2] <= ctl.prev_vec.z * dir_q.z;
    pp_r[3] <= ctl.old_vec.x * dir_q.x;
    pp_r[4] <= ctl.old_vec.y * dir_q.y;
    pp_r[5] <= ctl.old_vec.z * dir_q.z;
    j2_r <= j1_r;
    ch2_r <= ch1_r;
    sc2_r <= sc1_r;
    a2_r <= abs_a[TERM_W-1:0];
    d2_r <= abs_d[TERM_W-1:0];
    j3_r <= j2_r;
    ch3_r <= ch2_r;
    sc3_r <= sum3[SCORE_W-1:0];
    d3_r <= d2_r;
    j4_r <= j3_r;
    ch4_r <= ch3_r;
    sc4_r <= sc4_nxt;
    if (v4_r && !ch4_r && (!found_r || sc4_r < best_sc_r)) begin
      best_sc_r <= sc4_r;
      best_r <= j4_r;
    end
  end

  assign score_wr.en          = v4_r;
  assign score_wr.addr        = j4_r;
  assign score_wr.data.chosen = ch4_r;
  assign score_wr.data.score  = sc4_r;
  assign busy     = v0_r | v1_r | v2_r | v3_r | v4_r;
  assign found    = found_r;
  assign best_idx = best_r;

  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |-> !busy)
    else $error("walk cleared while busy");
  a_found_after: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !ch4_r) |=> found_r)
    else $error("unchosen entry did not set found");
  a_issue_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |-> !issue_valid)
    else $error("issue during clear");

endmodule

### design/perpendicular_greedy_order_unit.sv
// Top level: greedy perpendicular presentation order over stored image directions.
//   channel | ports                          | direction
//   input   | in_valid, in_stall, in_item    | commands in (load, start, step)
//   result  | out_valid, out_stall, out_item | chosen image per position
//   config  | cfg_valid, cfg_ready, cfg_*    | window_enable, window_length
// Load stores one direction; start writes order position zero and then emits;
// step runs through setup states PREP1, PREP2 and PREP3, which fetch the previous
// and the window-leaving vectors, one score-memory pass (WALK), DRAIN and EMIT.
// The score pass reads and writes one entry a cycle; the first step after
// start ignores stored scores, so no clearing pass is needed after reset.
// One item at a time; a result waits in the output register while the next
// item is accepted, and a new result waits for that register to drain.
module perpendicular_greedy_order_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pgo_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pgo_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pgo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pgo_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP1 = 3'd1;
  localparam logic [2:0] ST_PREP2 = 3'd2;
  localparam logic [2:0] ST_PREP3 = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, next_pos_r, cnt_r;
  logic             win_en_r;
  logic [CNT_W-1:0] win_len_r;
  logic [IDX_W-1:0] prev_r, pend_pos_r, pend_img_r;
  dir_t             pvec_r, ovec_r;
  logic             first_r, sub_r;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic             accept;
  logic             dir_we, ord_we;
  logic [IDX_W-1:0] dir_waddr, dir_raddr, ord_waddr, ord_raddr;
  dir_t             dir_wdata, dir_q;
  logic [IDX_W-1:0] ord_wdata, ord_q;
  score_ent_t       score_q;
  score_wr_t        score_wr;
  walk_ctl_t        ctl;
  logic             busy, found;
  logic [IDX_W-1:0] best_idx;
  logic [CNT_W-1:0] old_pos;
  logic             can_emit;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign old_pos   = next_pos_r - win_len_r - CNT_W'(1);
  assign can_emit  = !out_valid_r || !out_stall;

  assign ctl.clr      = (state_r == ST_PREP3);
  assign ctl.first    = first_r;
  assign ctl.sub      = sub_r;
  assign ctl.prev_idx = prev_r;
  assign ctl.prev_vec = pvec_r;
  assign ctl.old_vec  = ovec_r;

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = count_r[IDX_W-1:0];
    dir_wdata = '{x: in_item.dir_x, y: in_item.dir_y, z: in_item.dir_z};
    ord_we    = 1'b0;
    ord_waddr = next_pos_r[IDX_W-1:0];
    ord_wdata = best_idx;
    ord_raddr = old_pos[IDX_W-1:0];
    dir_raddr = cnt_r[IDX_W-1:0];
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.command == CMD_LOAD && count_r < CNT_W'(MAX_IMAGES)) begin
            dir_we = 1'b1;
          end else if (in_item.command == CMD_START &&
                       {1'b0, in_item.start_index} < count_r) begin
            ord_we    = 1'b1;
            ord_waddr = '0;
            ord_wdata = in_item.start_index;
            state_nxt = ST_EMIT;
          end else if (in_item.command == CMD_STEP && next_pos_r != '0 &&
                       next_pos_r < count_r) begin
            state_nxt = ST_PREP1;
          end
        end
      end
      ST_PREP1: begin
        dir_raddr = prev_r;
        state_nxt = ST_PREP2;
      end
      ST_PREP2: begin
        dir_raddr = ord_q;
        state_nxt = ST_PREP3;
      end
      ST_PREP3: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (cnt_r == count_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          ord_we    = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      next_pos_r  <= '0;
      win_en_r    <= 1'b1;
      win_len_r   <= CNT_W'(2);
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_ENABLE) begin
          win_en_r <= cfg_data[0];
        end else if (cfg_index == REG_WINDOW_LENGTH) begin
          win_len_r <= cfg_data;
        end
      end
      if (dir_we) begin
        count_r    <= count_r + CNT_W'(1);
        next_pos_r <= '0;
      end
      if (state_r == ST_IDLE && ord_we) begin
        next_pos_r <= CNT_W'(1);
      end
      if (state_r == ST_DRAIN && ord_we) begin
        next_pos_r <= next_pos_r + CNT_W'(1);
      end
      if (state_r == ST_PREP3) begin
        cnt_r <= '0;
      end else if (state_r == ST_WALK) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_EMIT && can_emit) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && ord_we) begin
      prev_r     <= in_item.start_index;
      pend_pos_r <= '0;
      pend_img_r <= in_item.start_index;
    end
    if (state_r == ST_DRAIN && ord_we) begin
      prev_r     <= best_idx;
      pend_pos_r <= next_pos_r[IDX_W-1:0];
      pend_img_r <= best_idx;
    end
    if (state_r == ST_PREP1) begin
      first_r <= (next_pos_r == CNT_W'(1));
      sub_r   <= win_en_r && (next_pos_r > win_len_r);
    end
    if (state_r == ST_PREP2) begin
      pvec_r <= dir_q;
    end
    if (state_r == ST_PREP3) begin
      ovec_r <= dir_q;
    end
    if (state_r == ST_EMIT && can_emit) begin
      out_item_r.order_position <= pend_pos_r;
      out_item_r.image_index    <= pend_img_r;
      out_item_r.last <= ({1'b0, pend_pos_r} + CNT_W'(1)) == count_r;
    end
  end

  pgo_ram #(.WIDTH($bits(dir_t)), .DEPTH(MAX_IMAGES)) u_dir_ram (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_q)
  );

  pgo_ram #(.WIDTH($bits(score_ent_t)), .DEPTH(MAX_IMAGES)) u_score_ram (
    .clk(clk), .we(score_wr.en), .waddr(score_wr.addr), .wdata(score_wr.data),
    .raddr(cnt_r[IDX_W-1:0]), .rdata(score_q)
  );

  pgo_ram #(.WIDTH(IDX_W), .DEPTH(MAX_IMAGES)) u_order_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_q)
  );

  pgo_walk u_walk (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .issue_valid(state_r == ST_WALK), .issue_idx(cnt_r[IDX_W-1:0]),
    .dir_q(dir_q), .score_q(score_q), .score_wr(score_wr),
    .busy(busy), .found(found), .best_idx(best_idx)
  );

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_pos_r <= count_r)
    else $error("next position beyond image count");
  a_found_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && !busy) |-> found)
    else $error("step finished without a candidate");
  a_wr_walk: assert property (@(posedge clk) disable iff (!rst_n)
    score_wr.en |-> (state_r == ST_WALK || state_r == ST_DRAIN))
    else $error("score write outside a step");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_IMAGES))
    else $error("image count overflow");

endmodule
